>>> rtl/prf_pkg.sv
package prf_pkg;

	localparam int PAGE_W  = 16;
	localparam int FRAME_W = 2;
	localparam int FAULT_W = 16;

	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	typedef enum logic {
		POL_FIFO = 1'b0,
		POL_LRU  = 1'b1
	} policy_t;

	// outcome of one lookup, handed from the lookup logic to the frame table
	typedef struct packed {
		logic hit;
		logic evict;
		logic fifo_adv;
	} prf_dec_t;

endpackage

>>> rtl/prf_lookup.sv
module prf_lookup import prf_pkg::*; #(
	parameter int NUM_FRAMES = 4
) (
	input  logic [PAGE_W-1:0]                      page,
	input  policy_t                                policy,
	input  logic [NUM_FRAMES-1:0][PAGE_W-1:0]      frame_page,
	input  logic [NUM_FRAMES-1:0]                  frame_valid,
	input  logic [NUM_FRAMES-1:0][$clog2(NUM_FRAMES)-1:0] frame_rank,
	input  logic [$clog2(NUM_FRAMES)-1:0]          fifo_next,
	output prf_dec_t                               dec,
	output logic [$clog2(NUM_FRAMES)-1:0]          frame_sel,
	output logic [PAGE_W-1:0]                      evict_page
);

	localparam int FW = $clog2(NUM_FRAMES);
	localparam logic [FW-1:0] LRU_RANK = FW'(NUM_FRAMES - 1);

	logic [NUM_FRAMES-1:0] match;
	logic [NUM_FRAMES-1:0] is_lru;
	logic [FW-1:0]         hit_idx;
	logic [FW-1:0]         empty_idx;
	logic [FW-1:0]         lru_idx;
	logic                  any_hit;
	logic                  full;

	always_comb begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			match[i]  = frame_valid[i] && (frame_page[i] == page);
			is_lru[i] = (frame_rank[i] == LRU_RANK);
		end
	end

	// lowest index wins: scan downward so the last assignment is the lowest
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		lru_idx   = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (match[i])
				hit_idx = FW'(i);
			if (!frame_valid[i])
				empty_idx = FW'(i);
			if (is_lru[i])
				lru_idx = FW'(i);
		end
	end

	assign any_hit = |match;
	assign full    = &frame_valid;

	always_comb begin
		dec.hit      = any_hit;
		dec.evict    = !any_hit && full;
		dec.fifo_adv = !any_hit && full && (policy == POL_FIFO);
		priority if (any_hit) begin
			frame_sel = hit_idx;
		end else if (!full) begin
			frame_sel = empty_idx;
		end else if (policy == POL_LRU) begin
			frame_sel = lru_idx;
		end else begin
			frame_sel = fifo_next;
		end
		evict_page = dec.evict ? frame_page[frame_sel] : '0;
	end

endmodule

>>> rtl/prf_frames.sv
module prf_frames import prf_pkg::*; #(
	parameter int NUM_FRAMES = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   upd,
	input  logic [PAGE_W-1:0]                      page,
	input  prf_dec_t                               dec,
	input  logic [$clog2(NUM_FRAMES)-1:0]          frame_sel,
	output logic [NUM_FRAMES-1:0][PAGE_W-1:0]      frame_page,
	output logic [NUM_FRAMES-1:0]                  frame_valid,
	output logic [NUM_FRAMES-1:0][$clog2(NUM_FRAMES)-1:0] frame_rank,
	output logic [$clog2(NUM_FRAMES)-1:0]          fifo_next,
	output logic [FAULT_W-1:0]                     faults_nxt
);

	localparam int FW = $clog2(NUM_FRAMES);
	localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);

	logic [NUM_FRAMES-1:0][PAGE_W-1:0] page_q;
	logic [NUM_FRAMES-1:0]             valid_q;
	logic [NUM_FRAMES-1:0][FW-1:0]     rank_q;
	logic [FW-1:0]                     fifo_next_q;
	logic [FAULT_W-1:0]                faults_q;
	logic                              sel_valid;
	logic [FW-1:0]                     sel_rank;

	assign frame_page  = page_q;
	assign frame_valid = valid_q;
	assign frame_rank  = rank_q;
	assign fifo_next   = fifo_next_q;
	assign sel_valid   = valid_q[frame_sel];
	assign sel_rank    = rank_q[frame_sel];

	always_comb begin
		faults_nxt = faults_q;
		if (!dec.hit && (faults_q != FAULT_MAX))
			faults_nxt = faults_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (upd)
			page_q[frame_sel] <= page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rank_q      <= '0;
			fifo_next_q <= '0;
			faults_q    <= '0;
		end else if (upd) begin
			valid_q[frame_sel] <= 1'b1;
			faults_q           <= faults_nxt;
			// age every valid frame more recent than the touched one; an empty frame is oldest
			for (int i = 0; i < NUM_FRAMES; i++) begin
				if (FW'(i) == frame_sel) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (!sel_valid || rank_q[i] < sel_rank)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (dec.fifo_adv)
				fifo_next_q <= (fifo_next_q == LAST_FRAME) ? '0 : fifo_next_q + 1'b1;
		end
	end

	// frames fill lowest first and are never emptied
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q & (valid_q + 1'b1)) == '0))
		else $error("frame valid bits are not filled from frame 0 upward");

	a_fifo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_next_q <= LAST_FRAME))
		else $error("round robin pointer out of range");

	a_faults_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(faults_q >= $past(faults_q)))
		else $error("fault count went down");

endmodule

>>> rtl/page_frame_replacement_core.sv
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------------
// in       | in_valid / in_stall   | page
// out      | out_valid / out_stall | hit, frame, evicted_valid, evicted_page, fault_count
// cfg      | cfg_valid / cfg_ready | policy
//
// One page reference per cycle while out_stall does not hold a result; each reference passes
// the input register, then the tag compare and frame table update, which set the rate,
// and then the result register.
// Reset empties all frames and clears ranks, round robin pointer, fault count and policy.
// out_stall holds the result; in_stall rises only while a reference waits behind it.
module page_frame_replacement_core import prf_pkg::*; #(
	parameter int NUM_FRAMES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PAGE_W-1:0]  page,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [FRAME_W-1:0] frame,
	output logic               evicted_valid,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [FAULT_W-1:0] fault_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               policy
);

	localparam int FW = $clog2(NUM_FRAMES);

	logic                              valid_s1;
	logic [PAGE_W-1:0]                 page_s1;
	logic                              adv;
	logic                              upd;
	policy_t                           policy_q;
	logic                              out_valid_q;
	logic                              hit_q;
	logic [FRAME_W-1:0]                frame_q;
	logic                              evicted_valid_q;
	logic [PAGE_W-1:0]                 evicted_page_q;
	logic [FAULT_W-1:0]                fault_count_q;

	logic [NUM_FRAMES-1:0][PAGE_W-1:0] frame_page;
	logic [NUM_FRAMES-1:0]             frame_valid;
	logic [NUM_FRAMES-1:0][FW-1:0]     frame_rank;
	logic [FW-1:0]                     fifo_next;
	logic [FAULT_W-1:0]                faults_nxt;
	prf_dec_t                          dec;
	logic [FW-1:0]                     frame_sel;
	logic [PAGE_W-1:0]                 evict_page;

	assign adv      = !out_valid_q || !out_stall;
	assign upd      = adv && valid_s1;
	assign in_stall = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
		end else if (cfg_valid && cfg_ready) begin
			policy_q <= policy_t'(policy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			page_s1 <= page;
	end

	prf_lookup #(.NUM_FRAMES(NUM_FRAMES)) u_lookup (
		.page        (page_s1),
		.policy      (policy_q),
		.frame_page  (frame_page),
		.frame_valid (frame_valid),
		.frame_rank  (frame_rank),
		.fifo_next   (fifo_next),
		.dec         (dec),
		.frame_sel   (frame_sel),
		.evict_page  (evict_page)
	);

	prf_frames #(.NUM_FRAMES(NUM_FRAMES)) u_frames (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.page        (page_s1),
		.dec         (dec),
		.frame_sel   (frame_sel),
		.frame_page  (frame_page),
		.frame_valid (frame_valid),
		.frame_rank  (frame_rank),
		.fifo_next   (fifo_next),
		.faults_nxt  (faults_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			hit_q           <= dec.hit;
			frame_q         <= FRAME_W'(frame_sel);
			evicted_valid_q <= dec.evict;
			evicted_page_q  <= evict_page;
			fault_count_q   <= faults_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame         = frame_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_count   = fault_count_q;

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && evicted_valid_q))
		else $error("hit reported together with an eviction");

	a_miss_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (fault_count_q != '0))
		else $error("miss reported with zero fault count");

endmodule

>>> sim/page_frame_replacement_core_tb.sv
module page_frame_replacement_core_tb import prf_pkg::*; ();

	localparam int NUM_FRAMES    = 4;
	localparam int WD_LIMIT      = 2000;
	localparam int POOL_SIZE     = 6;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [FAULT_W-1:0] fault_count;
	} lookup_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [PAGE_W-1:0]  ref_page   = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic               hit;
	logic [FRAME_W-1:0] frame;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;
	logic [FAULT_W-1:0] fault_count;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic               cfg_policy = 1'b0;

	// predicted frame table
	logic [PAGE_W-1:0]  tbl_page [NUM_FRAMES];
	bit                 tbl_used [NUM_FRAMES];
	int unsigned        tbl_rank [NUM_FRAMES];
	int unsigned        rr_victim;
	logic [FAULT_W-1:0] fault_tot;
	policy_t            cur_policy;

	lookup_t pending_results [$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_len     = 0;
	int idle_cycles  = 0;
	int err_cnt      = 0;
	int n_refs       = 0;
	int n_hits       = 0;
	int n_evicts     = 0;

	page_frame_replacement_core #(
		.NUM_FRAMES(NUM_FRAMES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page         (ref_page),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.frame        (frame),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_count  (fault_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.policy       (cfg_policy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lookup_t resolve_reference(input logic [PAGE_W-1:0] pg);
		lookup_t     res;
		int unsigned f;
		int unsigned old_rank;
		int unsigned best;
		bit          found;
		res   = '0;
		f     = 0;
		found = 1'b0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (!found && tbl_used[i] && tbl_page[i] == pg) begin
				f     = i;
				found = 1'b1;
			end
		end
		res.hit = found;
		if (!found) begin
			if (fault_tot != FAULT_MAX)
				fault_tot++;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				if (!found && !tbl_used[i]) begin
					f     = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				if (cur_policy == POL_FIFO) begin
					f         = rr_victim;
					rr_victim = (rr_victim + 1) % NUM_FRAMES;
				end else begin
					// oldest rank wins, lowest index on a tie
					best = 0;
					f    = 0;
					for (int i = 0; i < NUM_FRAMES; i++) begin
						if (tbl_rank[i] > best) begin
							best = tbl_rank[i];
							f    = i;
						end
					end
				end
				res.evicted_valid = 1'b1;
				res.evicted_page  = tbl_page[f];
				n_evicts++;
			end
		end else
			n_hits++;
		// an empty frame ranks behind every resident one
		old_rank = tbl_used[f] ? tbl_rank[f] : NUM_FRAMES;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (i != f && tbl_used[i] && tbl_rank[i] < old_rank)
				tbl_rank[i]++;
		end
		tbl_rank[f]     = 0;
		tbl_page[f]     = pg;
		tbl_used[f]     = 1'b1;
		res.frame       = FRAME_W'(f);
		res.fault_count = fault_tot;
		return res;
	endfunction

	task automatic send_ref(input logic [PAGE_W-1:0] pg);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ref_page <= pg;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(resolve_reference(pg));
		n_refs++;
	endtask

	task automatic set_policy(input policy_t p);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid  <= 1'b1;
		cfg_policy <= p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		cur_policy = p;
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (exp_val !== act_val) begin
			err_cnt++;
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		lookup_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				err_cnt++;
				$error("result transaction with no pending page reference");
			end else begin
				exp_res = pending_results.pop_front();
				check_field("hit", 16'(exp_res.hit), 16'(hit));
				check_field("frame", 16'(exp_res.frame), 16'(frame));
				check_field("evicted_valid", 16'(exp_res.evicted_valid), 16'(evicted_valid));
				check_field("evicted_page", exp_res.evicted_page, evicted_page);
				check_field("fault_count", exp_res.fault_count, fault_count);
			end
		end
	end

	// receiver: random stall, or a long hold when requested
	always @(posedge clk) begin
		if (hold_len != 0) begin
			hold_len  <= hold_len - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < snk_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WD_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic test_fifo_fill_evict();
		logic [PAGE_W-1:0] seq [12] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000,
			16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h5555,
			16'hAAAA, 16'h0001};
		set_policy(POL_FIFO);
		foreach (seq[k])
			send_ref(seq[k]);
	endtask

	task automatic test_lru_evict();
		logic [PAGE_W-1:0] seq [10] = '{16'h0001, 16'h5555, 16'h1234, 16'h0001,
			16'hFFFF, 16'h5555, 16'h0000, 16'hAAAA, 16'h0001, 16'h1234};
		set_policy(POL_LRU);
		foreach (seq[k])
			send_ref(seq[k]);
	endtask

	task automatic test_random_mix(input int src_pct, input int snk_pct, input int count);
		logic [PAGE_W-1:0] pool [POOL_SIZE];
		logic [PAGE_W-1:0] pg;
		src_idle_pct = src_pct;
		snk_idle_pct <= snk_pct;
		for (int half = 0; half < 2; half++) begin
			set_policy(half ? POL_LRU : POL_FIFO);
			foreach (pool[k])
				pool[k] = 16'($urandom);
			// mostly a small working set so hits and evictions interleave
			for (int k = 0; k < count / 2; k++) begin
				if ($urandom_range(4) != 0)
					pg = pool[$urandom_range(POOL_SIZE - 1)];
				else
					pg = 16'($urandom);
				send_ref(pg);
			end
		end
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct <= 0;
		hold_len     <= 60;
		for (int k = 0; k < 16; k++)
			send_ref(16'h4000 + 16'(k % 6));
	endtask

	initial begin
		foreach (tbl_page[i]) begin
			tbl_page[i] = '0;
			tbl_used[i] = 1'b0;
			tbl_rank[i] = 0;
		end
		rr_victim  = 0;
		fault_tot  = '0;
		cur_policy = POL_FIFO;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fifo_fill_evict();
		test_lru_evict();
		test_random_mix(9, 62, 250);
		test_random_mix(62, 9, 250);
		test_random_mix(0, 0, 250);
		test_backpressure();

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d page references: %0d hits, %0d evictions, final fault count %0d",
			n_refs, n_hits, n_evicts, fault_tot);
		$display("Covered FIFO and LRU victims, policy switches and a long output hold");
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
rtl/prf_pkg.sv
rtl/prf_lookup.sv
rtl/prf_frames.sv
rtl/page_frame_replacement_core.sv
sim/page_frame_replacement_core_tb.sv
